// ===== hw/rtl/prfc_pkg.sv =====
// ---------------------------------------------------------------------------
// prfc_pkg: shared types and constants of the factor check unit
// Widths of the payload fields, parameter defaults, the sign codes and the
// control struct that the sequencer hands to the bit-serial Montgomery unit.
// ---------------------------------------------------------------------------
`default_nettype none
package prfc_pkg;
    localparam int ModulusBitsDefault  = 64;
    localparam int ExponentBitsDefault = 32;
    localparam int ModulusWidth        = 64;
    localparam int MultiplierWidth     = 64;
    localparam int ExponentWidth       = 32;
    localparam int SignWidth           = 2;
    localparam int Squarings           = 5;

    localparam logic [SignWidth-1:0] SignMinus = 2'b11;
    localparam logic [SignWidth-1:0] SignPlus  = 2'b01;

    typedef struct packed {
        logic start;
        logic busy;
    } t_mm_ctl;
endpackage
`default_nettype wire

// ===== hw/rtl/prfc_mont_mul.sv =====
// ---------------------------------------------------------------------------
// prfc_mont_mul: bit-serial Montgomery product
// Radix-2 interleaved product a*b/2^W mod p, one bit of a per cycle,
// followed by one final conditional subtract.
// ---------------------------------------------------------------------------
`default_nettype none
module prfc_mont_mul #(
    parameter int W = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire prfc_pkg::t_mm_ctl    i_ctl,
    input  wire logic [W-1:0]         i_a,
    input  wire logic [W-1:0]         i_b,
    input  wire logic [W-1:0]         i_p,
    output logic                      o_done,
    output logic [W-1:0]              o_res
);
    import prfc_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0] r_a;
    logic [W+1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;
    logic [W+1:0]  n_sum;
    logic [W+1:0]  n_half;
    logic [W+1:0]  n_sub;

    always_comb begin
        n_sum  = r_acc + ({2'b0, i_b} & {(W+2){r_a[0]}});
        n_sum  = n_sum + ({2'b0, i_p} & {(W+2){n_sum[0]}});
        n_half = n_sum >> 1;
        n_sub  = r_acc - {2'b0, i_p};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_a   <= i_a;
                r_acc <= '0;
            end else if (r_run) begin
                if (r_cnt == CW'(W)) begin
                    r_run <= 1'b0;
                    r_done <= 1'b1;
                    if (!n_sub[W+1]) begin
                        r_acc <= n_sub;
                    end
                end else begin
                    r_acc <= n_half;
                    r_a   <= r_a >> 1;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc[W-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/prfc_mod_double.sv =====
// ---------------------------------------------------------------------------
// prfc_mod_double: serial modular doubler
// Computes 2^W mod p by W doublings of one, one doubling per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module prfc_mod_double #(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_p,
    output logic              o_done,
    output logic [W-1:0]      o_res
);
    import prfc_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W:0]    r_v;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;
    logic [W:0]    n_dbl;
    logic [W:0]    n_sub;

    always_comb begin
        n_dbl = {r_v[W-1:0], 1'b0};
        n_sub = n_dbl - {1'b0, i_p};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_v   <= (W+1)'(1);
            end else if (r_run) begin
                r_v   <= n_sub[W] ? n_dbl : n_sub;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_v[W-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/proth_riesel_factor_check_unit.sv =====
// ---------------------------------------------------------------------------
// proth_riesel_factor_check_unit: Proth/Riesel candidate factor check
// Input word: modulus p, multiplier k, exponent n, sign. Output word:
// is_factor, bad_input. One result word per input word, valid/ready.
// Bad input (p even, p below 3, n zero) goes straight to S_OUT after accept.
// Otherwise, with L = floor(log2 n): form R = 2^W mod p by serial doubling,
// double it W more times to R^2 mod p, reduce the 64-bit k mod p bit by bit,
// then run Montgomery products (radix 2, one bit of the left operand per
// cycle): one to convert k, L squarings, one final. Each set bit of n adds
// a doubling step, a scan from bit E-1 finds the top bit of n, and S_CMP
// and S_OUT compare and load the output. One word is in work at a time;
// the next input word is accepted from the cycle after the result is loaded.
// The result sits in an output register until taken; the unit computes
// the next word meanwhile and holds it in S_OUT while the receiver stalls.
// Reset clears the state, the start strobes and the output valid flag; o_ready stays low while in reset.
// ---------------------------------------------------------------------------
`default_nettype none
module proth_riesel_factor_check_unit #(
    parameter int MODULUS_BITS  = prfc_pkg::ModulusBitsDefault,
    parameter int EXPONENT_BITS = prfc_pkg::ExponentBitsDefault
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [prfc_pkg::ModulusWidth-1:0]   i_modulus,
    input  wire logic [prfc_pkg::MultiplierWidth-1:0] i_multiplier,
    input  wire logic [prfc_pkg::ExponentWidth-1:0]  i_exponent,
    input  wire logic signed [prfc_pkg::SignWidth-1:0] i_sign,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_is_factor,
    output logic                                     o_bad_input
);
    import prfc_pkg::*;

    localparam int W  = MODULUS_BITS;
    localparam int E  = EXPONENT_BITS;
    localparam int EC = (E > 1) ? $clog2(E) : 1;
    localparam int DC = $clog2(MultiplierWidth);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RMOD  = 4'd1;
    localparam logic [3:0] S_R2    = 4'd2;
    localparam logic [3:0] S_KRED  = 4'd3;
    localparam logic [3:0] S_KCONV = 4'd4;
    localparam logic [3:0] S_FIND  = 4'd5;
    localparam logic [3:0] S_SQR   = 4'd6;
    localparam logic [3:0] S_DBL   = 4'd7;
    localparam logic [3:0] S_FINAL = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]                 r_state;
    logic [W-1:0]               r_p;
    logic [MultiplierWidth-1:0] r_k;
    logic [E-1:0]               r_n;
    logic [1:0]                 r_sgn;
    logic [EC-1:0]              r_bit;
    logic [DC-1:0]              r_dcnt;
    logic [W-1:0]               r_one;
    logic [W-1:0]               r_t;
    logic [W-1:0]               r_km;
    logic [W-1:0]               r_a;
    logic                       r_start;
    logic                       r_dstart;
    logic [W-1:0]               r_opa;
    logic [W-1:0]               r_opb;
    logic                       r_ovalid;
    logic                       r_fac;
    logic                       r_bad;
    logic                       r_wfac;
    logic                       r_wbad;
    logic                       r_first;

    t_mm_ctl            mm_ctl;
    logic               mm_done;
    logic [W-1:0]       mm_res;
    logic               md_done;
    logic [W-1:0]       md_res;
    logic [W-1:0]       p_in;
    logic [E-1:0]       n_in;
    logic [W:0]         dbl;
    logic [W:0]         dbl_sub;
    logic [W-1:0]       dbl_mod;
    logic [W:0]         kdbl;
    logic [W:0]         ksub;
    logic [W-1:0]       kred;
    logic               out_free;

    assign p_in = i_modulus[W-1:0];
    assign n_in = i_exponent[E-1:0];
    assign out_free = !r_ovalid || i_ready;
    assign o_ready = (r_state == S_IDLE) && i_rst_n;

    assign mm_ctl.start = r_start;
    assign mm_ctl.busy  = (r_state != S_IDLE);

    always_comb begin
        dbl     = {r_a, 1'b0};
        dbl_sub = dbl - {1'b0, r_p};
        dbl_mod = dbl_sub[W] ? dbl[W-1:0] : dbl_sub[W-1:0];
    end

    // shift the next bit of k into the residue, MSB first
    always_comb begin
        kdbl = {r_km, r_k[MultiplierWidth-1]};
        ksub = kdbl - {1'b0, r_p};
        kred = ksub[W] ? kdbl[W-1:0] : ksub[W-1:0];
    end

    prfc_mod_double #(.W(W)) u_rmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_p     (r_p),
        .o_done  (md_done),
        .o_res   (md_res)
    );

    prfc_mont_mul #(.W(W)) u_mm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mm_ctl),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .i_p     (r_p),
        .o_done  (mm_done),
        .o_res   (mm_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= 1'b0;
            r_dstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_start  <= 1'b0;
            r_dstart <= 1'b0;
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_p   <= p_in;
                        r_k   <= i_multiplier;
                        r_n   <= n_in;
                        r_sgn <= i_sign;
                        if (!p_in[0] || p_in < W'(3) || n_in == '0) begin
                            r_wfac  <= 1'b0;
                            r_wbad  <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_wbad   <= 1'b0;
                            r_dstart <= 1'b1;
                            r_state  <= S_RMOD;
                        end
                    end
                end
                S_RMOD: begin
                    if (md_done) begin
                        r_one   <= md_res;
                        r_a     <= md_res;
                        r_dcnt  <= '0;
                        r_state <= S_R2;
                    end
                end
                S_R2: begin
                    // double R another W times to R^2
                    r_a <= dbl_mod;
                    if (r_dcnt == DC'(W - 1)) begin
                        r_t     <= dbl_mod;
                        r_km    <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_KRED;
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_KRED: begin
                    r_km <= kred;
                    r_k  <= r_k << 1;
                    if (r_dcnt == DC'(MultiplierWidth - 1)) begin
                        r_opa   <= kred;
                        r_opb   <= r_t;
                        r_start <= 1'b1;
                        r_state <= S_KCONV;
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_KCONV: begin
                    if (mm_done) begin
                        r_km    <= mm_res;
                        r_bit   <= EC'(E - 1);
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (r_n[r_bit]) begin
                        r_a     <= r_one;
                        r_state <= S_DBL;
                        r_first <= 1'b1;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_DBL: begin
                    if (r_first) begin
                        r_a     <= dbl_mod;
                        r_first <= 1'b0;
                        if (r_bit == '0) begin
                            r_opa   <= dbl_mod;
                            r_opb   <= r_km;
                            r_start <= 1'b1;
                            r_state <= S_FINAL;
                        end else begin
                            r_bit   <= r_bit - 1'b1;
                            r_opa   <= dbl_mod;
                            r_opb   <= dbl_mod;
                            r_start <= 1'b1;
                            r_state <= S_SQR;
                        end
                    end
                end
                S_SQR: begin
                    if (mm_done) begin
                        r_a <= mm_res;
                        if (r_n[r_bit]) begin
                            r_first <= 1'b1;
                            r_state <= S_DBL;
                        end else if (r_bit == '0) begin
                            r_opa   <= mm_res;
                            r_opb   <= r_km;
                            r_start <= 1'b1;
                            r_state <= S_FINAL;
                        end else begin
                            r_bit   <= r_bit - 1'b1;
                            r_opa   <= mm_res;
                            r_opb   <= mm_res;
                            r_start <= 1'b1;
                        end
                    end
                end
                S_FINAL: begin
                    if (mm_done) begin
                        r_a     <= mm_res;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_wfac  <= (r_a == r_one && r_sgn == SignMinus) ||
                               (r_a == r_p - r_one && r_sgn == SignPlus);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_fac   <= r_wfac;
                        r_bad   <= r_wbad;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_is_factor = r_fac;
    assign o_bad_input = r_bad;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("accepted while busy");
    a_bad_no_fac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_input) |-> !o_is_factor)
        else $error("bad input flagged as factor");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state != S_IDLE))
        else $error("product started while idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_is_factor) && $stable(o_bad_input)))
        else $error("output overwritten");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the Proth/Riesel factor check unit
// Drives modulus, multiplier, exponent and sign words with random gaps and
// output stalls. A scoreboard computes k*2^n mod p directly in 128-bit
// arithmetic, predicts is_factor and bad_input, and checks every result in
// order. Stimulus mixes directed corner words, well-formed random words,
// words built to be true factors, and raw noise.
// ---------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic is_factor;
    logic bad_input;
} t_verdict;

class factor_scoreboard;
    t_verdict pending[$];
    int       errors;

    static function logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] p);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, p});
    endfunction

    static function logic [63:0] powmod(logic [63:0] base, logic [31:0] n, logic [63:0] p);
        logic [63:0] acc;
        logic [63:0] b;
        acc = 64'd1 % p;
        b = base % p;
        for (int i = 31; i >= 0; i--) begin
            acc = mulmod(acc, acc, p);
            if (n[i]) begin
                acc = mulmod(acc, b, p);
            end
        end
        return acc;
    endfunction

    function void note(logic [63:0] p, logic [63:0] k, logic [31:0] n, logic [1:0] sgn);
        t_verdict    v;
        logic [63:0] x;
        v.is_factor = 1'b0;
        v.bad_input = 1'b0;
        if (!p[0] || p < 64'd3 || n == 32'd0) begin
            v.bad_input = 1'b1;
        end else begin
            x = mulmod(k % p, powmod(64'd2, n, p), p);
            if (sgn == prfc_pkg::SignMinus && x == 64'd1) begin
                v.is_factor = 1'b1;
            end else if (sgn == prfc_pkg::SignPlus && x == p - 64'd1) begin
                v.is_factor = 1'b1;
            end
        end
        pending.push_back(v);
    endfunction

    task report(string msg);
        $display("[%0t] %s", $realtime, msg);
        errors++;
    endtask

    task check(logic is_factor, logic bad_input);
        t_verdict v;
        if (pending.size() == 0) begin
            report("result word with nothing expected");
        end else begin
            v = pending.pop_front();
            if (is_factor !== v.is_factor) begin
                report($sformatf("is_factor got %b want %b", is_factor, v.is_factor));
            end
            if (bad_input !== v.bad_input) begin
                report($sformatf("bad_input got %b want %b", bad_input, v.bad_input));
            end
        end
    endtask
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_modulus = '0;
    logic [63:0] i_multiplier = '0;
    logic [31:0] i_exponent = '0;
    logic signed [1:0] i_sign = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_is_factor;
    logic        o_bad_input;

    factor_scoreboard sb = new();
    bit  busy_mode = 1'b0;
    int  idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    proth_riesel_factor_check_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_modulus(i_modulus), .i_multiplier(i_multiplier),
        .i_exponent(i_exponent), .i_sign(i_sign),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_is_factor(o_is_factor), .o_bad_input(o_bad_input)
    );

    function automatic int draw_gap();
        return busy_mode ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // k with k*2^n = +1 (minus) or -1 (plus) mod p, plus a random multiple of p
    function automatic logic [63:0] hit_multiplier(logic [63:0] p, logic [31:0] n,
                                                   logic [1:0] sgn);
        logic [63:0] half;
        logic [63:0] k;
        logic [63:0] m;
        half = p / 2 + 64'd1;
        k = sb.powmod(half, n, p);
        if (sgn == prfc_pkg::SignPlus) begin
            k = (k == 0) ? 64'd0 : p - k;
        end
        m = (p > 64'hFFFF) ? 64'($urandom_range(0, 3)) : 64'($urandom_range(0, 65535));
        return k + m * p;
    endfunction

    function automatic logic [31:0] rand_exponent();
        int w;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
        return ($urandom() >> (32 - w)) | 32'd1 << (w - 1);
    endfunction

    function automatic logic [63:0] rand_modulus();
        int w;
        w = $urandom_range(2, 64);
        return (rand64() >> (64 - w)) | 64'd1 | 64'd1 << (w - 1);
    endfunction

    task send(logic [63:0] p, logic [63:0] k, logic [31:0] n, logic [1:0] sgn);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_modulus    <= p;
        i_multiplier <= k;
        i_exponent   <= n;
        i_sign       <= sgn;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note(p, k, n, sgn);
    endtask

    task send_random();
        logic [63:0] p;
        logic [31:0] n;
        logic [1:0]  sgn;
        int          pick;
        pick = $urandom_range(0, 99);
        p = rand_modulus();
        n = rand_exponent();
        sgn = 2'($urandom());
        if (pick < 25) begin
            sgn = $urandom_range(0, 1) ? prfc_pkg::SignMinus : prfc_pkg::SignPlus;
            send(p, hit_multiplier(p, n, sgn), n, sgn);
        end else if (pick < 85) begin
            send(p, rand64(), n, sgn);
        end else begin
            send(rand64(), rand64(), $urandom_range(0, 3) == 0 ? 32'd0 : $urandom(), sgn);
        end
    endtask

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            sb.check(o_is_factor, o_bad_input);
        end
    end

    initial begin
        logic [63:0] pmax;
        pmax = 64'hFFFF_FFFF_FFFF_FFC5;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(64'd0, 64'd5, 32'd3, prfc_pkg::SignMinus);
        send(64'd1, 64'd5, 32'd3, prfc_pkg::SignMinus);
        send(64'd2, 64'd5, 32'd3, prfc_pkg::SignPlus);
        send(64'hFFFF_FFFF_FFFF_FFFE, 64'd1, 32'd1, prfc_pkg::SignPlus);
        send(64'd7, 64'd3, 32'd0, prfc_pkg::SignMinus);
        send(64'd3, 64'd1, 32'd1, prfc_pkg::SignPlus);
        send(64'd7, 64'd1, 32'd3, prfc_pkg::SignMinus);
        send(64'd7, 64'd1, 32'd3, 2'b00);
        send(64'd7, 64'd1, 32'd3, 2'b10);
        send(64'd5, 64'd1, 32'd2, prfc_pkg::SignPlus);
        send(64'd5, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, prfc_pkg::SignMinus);
        send(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
             prfc_pkg::SignPlus);
        send(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'd1, prfc_pkg::SignMinus);
        send(pmax, hit_multiplier(pmax, 32'hFFFF_FFFF, prfc_pkg::SignMinus), 32'hFFFF_FFFF,
             prfc_pkg::SignMinus);
        send(pmax, hit_multiplier(pmax, 32'd1, prfc_pkg::SignPlus), 32'd1,
             prfc_pkg::SignPlus);
        send(64'd1000003, 64'd1000003 * 7 + 1, 32'd64, prfc_pkg::SignMinus);
        send(64'd11, 64'd11 * 5, 32'd9, prfc_pkg::SignPlus);

        for (int i = 0; i < 1150; i++) begin
            if (i % 100 == 0) begin
                busy_mode = ($urandom_range(0, 3) == 0);
            end
            send_random();
        end
        busy_mode = 1'b0;
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/prfc_pkg.sv
hw/rtl/prfc_mont_mul.sv
hw/rtl/prfc_mod_double.sv
hw/rtl/proth_riesel_factor_check_unit.sv
dv/tb_top.sv
